// ----- sv/sbtg_pkg.sv -----
// ----------------------------------------------------------------------------
// sbtg_pkg
// Shared types, constants and the quarter-wave sine table for the sine burst
// tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbtg_pkg;

	// field and register widths
	localparam int STEP_W        = 31;
	localparam int POSITION_BITS = 24;
	localparam int PHASE_W       = 32;
	localparam int CHANS_W       = 4;
	localparam int CHAN_W        = 3;
	localparam int SAMPLE_W      = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 31;
	localparam int MAX_CHANNELS  = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// reset values of the registers
	localparam logic [STEP_W-1:0]        RST_PHASE_STEP    = 31'd39370534;
	localparam logic [POSITION_BITS-1:0] RST_NOTE_LENGTH   = 24'd48000;
	localparam logic [CHANS_W-1:0]       RST_CHANNEL_COUNT = 4'd2;

	// sine table geometry
	localparam int SINE_TABLE_BITS = 8;
	localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
	localparam int TIDX_W          = SINE_TABLE_BITS + 1;
	localparam int TVAL_W          = 15;

	// frame queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// one classified frame, handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       written;
		logic [CHANS_W-1:0]         chans;
	} frame_t;

	typedef logic [TVAL_W-1:0] qw_table_t [0:TABLE_SIZE];

	// one table entry: truncated taylor series of sin in Q2.30, rounded to Q1.15
	function automatic logic [TVAL_W-1:0] table_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] r;
		x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
		x2   = (x * x) >> 30;
		sum  = $signed(x);
		term = ((x * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0)
			sum = 0;
		if (sum > 64'sd1073741824)
			sum = 64'sd1073741824;
		r = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		return r[TVAL_W-1:0];
	endfunction

	function automatic qw_table_t build_table();
		qw_table_t t;
		for (int unsigned k = 0; k <= TABLE_SIZE; k++)
			t[k] = table_entry(k);
		return t;
	endfunction

	localparam qw_table_t QUARTER_WAVE = build_table();

endpackage

`default_nettype wire

// ----- sv/sbtg_front.sv -----
// ----------------------------------------------------------------------------
// sbtg_front
// Holds the registers and the note state, accepts frame requests, classifies
// each frame and looks up its sample, then hands the frame to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbtg_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [sbtg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [sbtg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  push,
	input  wire                                  first_of_block,
	input  wire                                  restart,
	input  wire  [sbtg_pkg::QCNT_W-1:0]          q_count,
	output logic                                 full,
	output logic                                 frame_valid,
	output sbtg_pkg::frame_t                     frame
);

	localparam logic [sbtg_pkg::POSITION_BITS-1:0] POS_MAX = '1;

	logic [sbtg_pkg::STEP_W-1:0]        phase_step_q;
	logic [sbtg_pkg::POSITION_BITS-1:0] note_length_q;
	logic [sbtg_pkg::CHANS_W-1:0]       channel_count_q;

	logic [sbtg_pkg::POSITION_BITS-1:0] position_q;
	logic [sbtg_pkg::PHASE_W-1:0]       phase_q;
	logic                               skip_q;

	logic                               valid_s1;
	logic                               play_s1;
	logic                               neg_s1;
	logic [sbtg_pkg::TIDX_W-1:0]        tidx_s1;
	logic                               written_s1;
	logic [sbtg_pkg::CHANS_W-1:0]       chans_s1;

	logic                               accept;
	logic [sbtg_pkg::POSITION_BITS-1:0] pos0;
	logic [sbtg_pkg::PHASE_W-1:0]       ph0;
	logic                               skip_n;
	logic                               play;
	logic                               advance;
	logic [sbtg_pkg::CHANS_W-1:0]       chans;
	logic [sbtg_pkg::TIDX_W-1:0]        raw_idx;
	logic [sbtg_pkg::TIDX_W-1:0]        tidx;
	logic [sbtg_pkg::TVAL_W-1:0]        tval;
	logic signed [sbtg_pkg::SAMPLE_W-1:0] mag;

	// room for this frame and the one in flight
	assign full   = ({1'b0, q_count} + {{sbtg_pkg::QCNT_W{1'b0}}, valid_s1})
	                >= (sbtg_pkg::QCNT_W + 1)'(sbtg_pkg::QUEUE_DEPTH);
	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= sbtg_pkg::RST_PHASE_STEP;
			note_length_q   <= sbtg_pkg::RST_NOTE_LENGTH;
			channel_count_q <= sbtg_pkg::RST_CHANNEL_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				sbtg_pkg::REG_PHASE_STEP:    phase_step_q    <= cfg_data;
				sbtg_pkg::REG_NOTE_LENGTH:   note_length_q   <= cfg_data[sbtg_pkg::POSITION_BITS-1:0];
				sbtg_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[sbtg_pkg::CHANS_W-1:0];
				default: ;
			endcase
		end
	end

	// classify the frame: restart, then block start check, then play
	always_comb begin
		pos0   = restart ? '0 : position_q;
		ph0    = restart ? '0 : phase_q;
		skip_n = skip_q;
		if (first_of_block) begin
			skip_n = (pos0 >= note_length_q);
			if (skip_n) begin
				pos0 = '0;
				ph0  = '0;
			end
		end
		play    = !skip_n && (pos0 < note_length_q);
		advance = play && (pos0 != POS_MAX);
		if (channel_count_q == '0)
			chans = sbtg_pkg::CHANS_W'(1);
		else if (channel_count_q > sbtg_pkg::CHANS_W'(sbtg_pkg::MAX_CHANNELS))
			chans = sbtg_pkg::CHANS_W'(sbtg_pkg::MAX_CHANNELS);
		else
			chans = channel_count_q;
		raw_idx = {1'b0, ph0[sbtg_pkg::PHASE_W-3 -: sbtg_pkg::SINE_TABLE_BITS]};
		tidx    = ph0[sbtg_pkg::PHASE_W-2]
		          ? sbtg_pkg::TIDX_W'(sbtg_pkg::TABLE_SIZE) - raw_idx : raw_idx;
	end

	// note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			phase_q    <= '0;
			skip_q     <= 1'b0;
		end else if (accept) begin
			skip_q <= skip_n;
			if (advance) begin
				position_q <= pos0 + 1'b1;
				phase_q    <= ph0 + {1'b0, phase_step_q};
			end else begin
				position_q <= pos0;
				phase_q    <= ph0;
			end
		end
	end

	// stage one: classified frame awaiting table lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			play_s1    <= play;
			neg_s1     <= ph0[sbtg_pkg::PHASE_W-1];
			tidx_s1    <= tidx;
			written_s1 <= !skip_n;
			chans_s1   <= chans;
		end
	end

	// table lookup and sign
	assign tval = sbtg_pkg::QUARTER_WAVE[tidx_s1];
	assign mag  = $signed({1'b0, tval});

	assign frame_valid   = valid_s1;
	assign frame.sample  = !play_s1 ? '0 : (neg_s1 ? -mag : mag);
	assign frame.written = written_s1;
	assign frame.chans   = chans_s1;

endmodule

`default_nettype wire

// ----- sv/sbtg_queue.sv -----
// ----------------------------------------------------------------------------
// sbtg_queue
// Short frame queue between the front and the channel expander.
// ----------------------------------------------------------------------------
`default_nettype none

module sbtg_queue (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           wr_en,
	input  sbtg_pkg::frame_t              wr_frame,
	input  wire                           rd_en,
	output logic                          head_valid,
	output sbtg_pkg::frame_t              head,
	output logic [sbtg_pkg::QCNT_W-1:0]   count
);

	sbtg_pkg::frame_t              mem_q [sbtg_pkg::QUEUE_DEPTH];
	logic [sbtg_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [sbtg_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [sbtg_pkg::QCNT_W-1:0]   count_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_frame;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;

endmodule

`default_nettype wire

// ----- sv/sbtg_back.sv -----
// ----------------------------------------------------------------------------
// sbtg_back
// Expands each queued frame into one result per channel and holds the oldest
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbtg_back (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    head_valid,
	input  sbtg_pkg::frame_t                       head,
	output logic                                   head_take,
	input  wire                                    pop,
	output logic                                   empty,
	output logic signed [sbtg_pkg::SAMPLE_W-1:0]   sample,
	output logic [sbtg_pkg::CHAN_W-1:0]            channel,
	output logic                                   written,
	output logic                                   last
);

	logic [sbtg_pkg::CHAN_W-1:0]          ch_q;
	logic                                 out_valid_q;
	logic signed [sbtg_pkg::SAMPLE_W-1:0] sample_q;
	logic [sbtg_pkg::CHAN_W-1:0]          channel_q;
	logic                                 written_q;
	logic                                 last_q;

	logic load;
	logic is_last;

	assign load      = head_valid && (!out_valid_q || pop);
	assign is_last   = ({1'b0, ch_q} + 1'b1) == head.chans;
	assign head_take = load && is_last;

	// channel counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				ch_q <= is_last ? '0 : ch_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			sample_q  <= head.sample;
			channel_q <= ch_q;
			written_q <= head.written;
			last_q    <= is_last;
		end
	end

	assign empty   = !out_valid_q;
	assign sample  = sample_q;
	assign channel = channel_q;
	assign written = written_q;
	assign last    = last_q;

endmodule

`default_nettype wire

// ----- sv/sine_burst_tone_generator_top.sv -----
// ----------------------------------------------------------------------------
// sine_burst_tone_generator_top
// Sine burst tone generator: plays a fixed-length sine note as interleaved
// multichannel frames.
// ----------------------------------------------------------------------------
// Each pushed frame request yields one result per channel (channel_count,
// clamped to 1 to 8; last set on the final one), read out like a queue through
// empty and pop. A frame request is classified in the cycle it is accepted and
// held in the stage-one register, from which its table lookup is done; the
// frame then passes through the queue into the output register. A four-entry
// frame queue lets requests keep coming while the channel expander drains.
// The expander emits one result per cycle while pop keeps taking results, and
// that expander sets the sustained rate. The sample is read from a 257-entry
// quarter-wave table without interpolation. The user must write registers
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce it.
`default_nettype none

module sine_burst_tone_generator_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [sbtg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [sbtg_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                    push,
	output logic                                   full,
	input  wire                                    first_of_block,
	input  wire                                    restart,
	output logic                                   empty,
	input  wire                                    pop,
	output logic signed [sbtg_pkg::SAMPLE_W-1:0]   sample,
	output logic [sbtg_pkg::CHAN_W-1:0]            channel,
	output logic                                   written,
	output logic                                   last
);

	logic                           frame_valid;
	sbtg_pkg::frame_t               frame;
	logic                           head_valid;
	sbtg_pkg::frame_t               head;
	logic                           head_take;
	logic [sbtg_pkg::QCNT_W-1:0]    q_count;

	// request side: registers, note state, classification
	sbtg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.first_of_block (first_of_block),
		.restart        (restart),
		.q_count        (q_count),
		.full           (full),
		.frame_valid    (frame_valid),
		.frame          (frame)
	);

	// frame queue
	sbtg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (frame_valid),
		.wr_frame   (frame),
		.rd_en      (head_take),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	// result side: channel expansion
	sbtg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take),
		.pop        (pop),
		.empty      (empty),
		.sample     (sample),
		.channel    (channel),
		.written    (written),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- test/sine_burst_tone_generator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_burst_tone_generator_top_tb
// Self-checking bench for the sine burst tone generator. Frame requests go in
// through push/full and per-channel samples come out through empty/pop. A
// scoreboard keeps its own sine table, phase accumulator and note position,
// predicts every channel copy and compares it field by field on arrival.
// ----------------------------------------------------------------------------

module sine_burst_tone_generator_top_tb;

	import sbtg_pkg::*;

	// index with no register behind it, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// predicts the channel copies of each frame and checks what comes out
	class tone_scoreboard;
		typedef struct {
			logic signed [SAMPLE_W-1:0] sample;
			logic [CHAN_W-1:0]          channel;
			logic                       written;
			logic                       last;
		} tone_copy_t;

		logic [TVAL_W-1:0]        sine_quarter [0:TABLE_SIZE];
		logic [STEP_W-1:0]        step;
		logic [POSITION_BITS-1:0] note_len;
		logic [CHANS_W-1:0]       chan_cfg;
		logic [POSITION_BITS-1:0] position;
		logic [PHASE_W-1:0]       phase;
		logic                     skipping;
		tone_copy_t               copies_due [$];
		int                       errors;

		function new();
			step     = RST_PHASE_STEP;
			note_len = RST_NOTE_LENGTH;
			chan_cfg = RST_CHANNEL_COUNT;
			position = '0;
			phase    = '0;
			skipping = 1'b0;
			errors   = 0;
			for (int k = 0; k <= TABLE_SIZE; k++)
				sine_quarter[k] = quarter_value(k);
		endfunction

		// sin(k * pi / 2N) by truncated taylor series in Q2.30, rounded to Q1.15
		function logic [TVAL_W-1:0] quarter_value(int unsigned k);
			logic [63:0]        x;
			logic [63:0]        x2;
			logic [63:0]        term;
			logic signed [63:0] acc;
			logic [63:0]        r;
			int                 n;
			x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = x;
			acc  = $signed(x);
			for (n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2)
					acc = acc - $signed(term);
				else
					acc = acc + $signed(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > 64'sd1073741824)
				acc = 64'sd1073741824;
			r = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
			return r[TVAL_W-1:0];
		endfunction

		// quadrant from the top two phase bits, no interpolation
		function logic signed [SAMPLE_W-1:0] sine_at(logic [PHASE_W-1:0] ph);
			int                         i;
			logic signed [SAMPLE_W-1:0] v;
			i = (ph >> (30 - SINE_TABLE_BITS)) & (TABLE_SIZE - 1);
			if (ph[30])
				v = $signed({1'b0, sine_quarter[TABLE_SIZE - i]});
			else
				v = $signed({1'b0, sine_quarter[i]});
			return ph[31] ? -v : v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP:    step     = data[STEP_W-1:0];
				REG_NOTE_LENGTH:   note_len = data[POSITION_BITS-1:0];
				REG_CHANNEL_COUNT: chan_cfg = data[CHANS_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted frame request: restart first, then the block start check
		function void note_frame(logic fob, logic rst);
			logic signed [SAMPLE_W-1:0] value;
			logic                       wr;
			int                         chans;
			tone_copy_t                 c;
			if (rst) begin
				position = '0;
				phase    = '0;
			end
			if (fob) begin
				if (position >= note_len) begin
					skipping = 1'b1;
					position = '0;
					phase    = '0;
				end else begin
					skipping = 1'b0;
				end
			end
			chans = int'(chan_cfg);
			if (chans == 0)
				chans = 1;
			if (chans > MAX_CHANNELS)
				chans = MAX_CHANNELS;
			value = '0;
			wr    = 1'b1;
			if (skipping) begin
				wr = 1'b0;
			end else if (position < note_len) begin
				value = sine_at(phase);
				// position saturates at its all-ones value
				if (position != '1) begin
					position = position + 1'b1;
					phase    = phase + PHASE_W'(step);
				end
			end
			for (int k = 0; k < chans; k++) begin
				c.sample  = value;
				c.channel = k[CHAN_W-1:0];
				c.written = wr;
				c.last    = (k == chans - 1);
				copies_due.push_back(c);
			end
		endfunction

		function int pending();
			return copies_due.size();
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic signed [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] ch,
				logic wr, logic lst);
			tone_copy_t e;
			if (copies_due.size() == 0) begin
				report($sformatf("unexpected result sample %0d channel %0d", s, ch));
				return;
			end
			e = copies_due.pop_front();
			if (s !== e.sample)
				report($sformatf("sample got %0d want %0d", s, e.sample));
			if (ch !== e.channel)
				report($sformatf("channel got %0d want %0d", ch, e.channel));
			if (wr !== e.written)
				report($sformatf("written got %b want %b", wr, e.written));
			if (lst !== e.last)
				report($sformatf("last got %b want %b", lst, e.last));
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       push;
	logic                       full;
	logic                       first_of_block;
	logic                       restart;
	logic                       empty;
	logic                       pop;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]          channel;
	logic                       written;
	logic                       last;

	tone_scoreboard sb;
	bit             steady;
	int             pop_hold;

	sine_burst_tone_generator_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.first_of_block (first_of_block),
		.restart        (restart),
		.empty          (empty),
		.pop            (pop),
		.sample         (sample),
		.channel        (channel),
		.written        (written),
		.last           (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one frame request transaction, called at a rising edge
	task automatic send_frame(logic fob, logic rst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push           <= 1'b1;
		first_of_block <= fob;
		restart        <= rst;
		do @(posedge clk); while (full);
		sb.note_frame(fob, rst);
	endtask

	// register write; the caller drops cfg_we after the last one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// hold off until every expected copy has come out
	task automatic settle_idle();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	// result side: random stalls on pop
	initial begin
		pop_hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(sample, channel, written, last);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop      <= 1'b1;
				pop_hold = pick_gap();
			end
		end
	end

	// stimulus
	initial begin
		logic [STEP_W-1:0]        step_val;
		logic [POSITION_BITS-1:0] len_val;
		int                       blen;
		int                       sent;
		int                       r;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_PHASE_STEP;
		cfg_data       = '0;
		push           = 1'b0;
		first_of_block = 1'b0;
		restart        = 1'b0;
		pop            = 1'b0;
		steady         = 1'b0;
		sb             = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: frames before any block start, block start, restart
		send_frame(1'b0, 1'b0);
		send_frame(1'b0, 1'b0);
		send_frame(1'b1, 1'b0);
		send_frame(1'b0, 1'b1);
		send_frame(1'b0, 1'b0);

		// zero note length, zero channels, largest step, unused index
		settle_idle();
		write_reg(REG_PHASE_STEP, 31'h7FFF_FFFF);
		write_reg(REG_NOTE_LENGTH, '0);
		write_reg(REG_CHANNEL_COUNT, '0);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		send_frame(1'b0, 1'b0);
		send_frame(1'b1, 1'b0);
		send_frame(1'b0, 1'b1);
		send_frame(1'b0, 1'b0);

		// quarter-turn step walks all quadrants, then the note ends and skips
		settle_idle();
		write_reg(REG_PHASE_STEP, 31'h4000_0000);
		write_reg(REG_NOTE_LENGTH, CFG_DATA_W'(5));
		write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(15));
		cfg_we <= 1'b0;
		send_frame(1'b1, 1'b0);
		repeat (5) send_frame(1'b0, 1'b0);
		send_frame(1'b1, 1'b0);
		send_frame(1'b0, 1'b0);

		// zero step, longest note, full channel count
		settle_idle();
		write_reg(REG_PHASE_STEP, '0);
		write_reg(REG_NOTE_LENGTH, CFG_DATA_W'(24'hFF_FFFF));
		write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(MAX_CHANNELS));
		cfg_we <= 1'b0;
		send_frame(1'b1, 1'b1);
		send_frame(1'b0, 1'b0);

		// random settings, mostly well-formed blocks of frames
		for (int p = 0; p < 8; p++) begin
			settle_idle();
			r = $urandom_range(0, 9);
			if (r == 0)
				step_val = '0;
			else if (r == 1)
				step_val = '1;
			else
				step_val = STEP_W'($urandom);
			r = $urandom_range(0, 19);
			if (r < 2)
				len_val = '0;
			else if (r == 2)
				len_val = '1;
			else if (r == 3)
				len_val = POSITION_BITS'($urandom);
			else
				len_val = POSITION_BITS'($urandom_range(1, 40));
			write_reg(REG_PHASE_STEP, step_val);
			write_reg(REG_NOTE_LENGTH, {7'($urandom), len_val});
			if ($urandom_range(0, 1))
				write_reg(REG_CHANNEL_COUNT, {27'($urandom), 4'($urandom_range(1, 8))});
			else
				write_reg(REG_CHANNEL_COUNT, {27'($urandom), 4'($urandom)});
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			cfg_we <= 1'b0;
			steady = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 41) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise frame
					send_frame(1'($urandom), 1'($urandom));
					sent++;
				end else begin
					blen = $urandom_range(1, 12);
					for (int k = 0; k < blen; k++)
						send_frame(k == 0, $urandom_range(0, 11) == 0);
					sent += blen;
				end
				if ($urandom_range(0, 29) == 0)
					settle_idle();
			end
		end

		// drain and let any stray result show up
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sine_burst_tone_generator_top.f -----
sv/sbtg_pkg.sv
sv/sbtg_front.sv
sv/sbtg_queue.sv
sv/sbtg_back.sv
sv/sine_burst_tone_generator_top.sv
test/sine_burst_tone_generator_top_tb.sv
